>>> hdl/start_byte_frame_receiver_unit_assert.svh
// Assertion macros used by the frame receiver checker.
`ifndef START_BYTE_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define START_BYTE_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SBFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sbfr assertion failed: %m");

// Implication whose consequent is checked on the clock edge after the antecedent.
`define SBFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbfr assertion failed: %m");

`endif

>>> hdl/sbfr_pkg.sv
// Package with types, codes and constants of the frame receiver.
package sbfr_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 32;
  localparam int EMIT_LIMIT = 32;
  localparam int QDEPTH = 2;

  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_CSUM_ERR = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  localparam logic [7:0] START_BYTE_RST = 8'd2;
  localparam logic [5:0] MAX_LENGTH_RST = 6'd32;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SRC,
    PH_DST,
    PH_LEN,
    PH_DATA,
    PH_CSUM
  } phase_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD,
    B_EMIT
  } back_e;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] source;
    logic [7:0] dest;
    logic [7:0] flen;
    logic       bank;
  } desc_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] source;
    logic [7:0] dest;
    logic [7:0] flen;
    logic [7:0] data;
    logic [4:0] pos;
    logic       last;
  } res_t;

endpackage

>>> hdl/sbfr_queue.sv
// Two-entry queue of frame descriptors between the parser and the emitter.
module sbfr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbfr_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output sbfr_pkg::desc_t desc_o,
  output logic            empty_o
);

  localparam int PW = (sbfr_pkg::QDEPTH > 1) ? $clog2(sbfr_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(sbfr_pkg::QDEPTH + 1);

  sbfr_pkg::desc_t entry_q [sbfr_pkg::QDEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CW'(sbfr_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign desc_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(sbfr_pkg::QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(sbfr_pkg::QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= desc_i;
    end
  end

endmodule

>>> hdl/sbfr_front.sv
// Byte parser: configuration, frame state machine, checksum and payload writes.
module sbfr_front #(
  parameter int PAYLOAD_DEPTH = sbfr_pkg::PAYLOAD_DEPTH_DEF,
  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              push_i,
  input  logic [7:0]        byte_i,
  output logic              full_o,
  output logic              q_push_o,
  output sbfr_pkg::desc_t   q_desc_o,
  input  logic              q_full_i,
  output sbfr_pkg::mem_wr_t wr_o,
  output logic [AW-1:0]     wr_addr_o,
  input  sbfr_pkg::rel_t    rel_i
);

  localparam logic [5:0] LIMIT_CAP =
    6'((PAYLOAD_DEPTH < sbfr_pkg::EMIT_LIMIT) ? PAYLOAD_DEPTH : sbfr_pkg::EMIT_LIMIT);

  sbfr_pkg::phase_e phase_q, phase_d;
  logic [7:0] start_q;
  logic [5:0] max_len_q;
  logic [7:0] src_q, src_d, dst_q, dst_d, sum_q, sum_d;
  logic [5:0] len_q, len_d, cnt_q, cnt_d, cnt_nx, eff_limit;
  logic       wbank_q, wbank_d;
  logic [1:0] busy_q, busy_d;
  logic       accept;

  assign full_o = (((phase_q == sbfr_pkg::PH_LEN) || (phase_q == sbfr_pkg::PH_CSUM))
                   && q_full_i)
                  || ((phase_q == sbfr_pkg::PH_DATA) && busy_q[wbank_q]);
  assign accept    = push_i && !full_o;
  assign eff_limit = (max_len_q > LIMIT_CAP) ? LIMIT_CAP : max_len_q;
  assign cnt_nx    = cnt_q + 6'd1;
  assign wr_addr_o = cnt_q[AW-1:0];

  always_comb begin
    phase_d  = phase_q;
    src_d    = src_q;
    dst_d    = dst_q;
    sum_d    = sum_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    wbank_d  = wbank_q;
    busy_d   = busy_q;
    q_push_o = 1'b0;
    q_desc_o = '{status: sbfr_pkg::ST_GOOD, source: src_q, dest: dst_q,
                 flen: {2'b00, len_q}, bank: wbank_q};
    wr_o     = '{en: 1'b0, bank: wbank_q, data: byte_i};
    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      unique case (phase_q)
        sbfr_pkg::PH_HUNT: begin
          if (byte_i == start_q) begin
            phase_d = sbfr_pkg::PH_SRC;
          end
        end
        sbfr_pkg::PH_SRC: begin
          src_d   = byte_i;
          sum_d   = byte_i;
          phase_d = sbfr_pkg::PH_DST;
        end
        sbfr_pkg::PH_DST: begin
          dst_d   = byte_i;
          sum_d   = sum_q + byte_i;
          phase_d = sbfr_pkg::PH_LEN;
        end
        sbfr_pkg::PH_LEN: begin
          if (byte_i > {2'b00, eff_limit}) begin
            q_push_o        = 1'b1;
            q_desc_o.status = sbfr_pkg::ST_OVERSIZE;
            q_desc_o.flen   = byte_i;
            phase_d         = sbfr_pkg::PH_HUNT;
          end else begin
            len_d   = byte_i[5:0];
            sum_d   = sum_q + byte_i;
            cnt_d   = '0;
            phase_d = (byte_i[5:0] == '0) ? sbfr_pkg::PH_CSUM : sbfr_pkg::PH_DATA;
          end
        end
        sbfr_pkg::PH_DATA: begin
          wr_o.en = 1'b1;
          sum_d   = sum_q + byte_i;
          cnt_d   = cnt_nx;
          if (cnt_nx >= len_q) begin
            phase_d = sbfr_pkg::PH_CSUM;
          end
        end
        sbfr_pkg::PH_CSUM: begin
          q_push_o = 1'b1;
          if (byte_i != sum_q) begin
            q_desc_o.status = sbfr_pkg::ST_CSUM_ERR;
          end else if (len_q != '0) begin
            wbank_d         = ~wbank_q;
            busy_d[wbank_q] = 1'b1;
          end
          phase_d = sbfr_pkg::PH_HUNT;
        end
        default: begin
          phase_d = sbfr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sbfr_pkg::PH_HUNT;
      wbank_q   <= 1'b0;
      busy_q    <= '0;
      start_q   <= sbfr_pkg::START_BYTE_RST;
      max_len_q <= sbfr_pkg::MAX_LENGTH_RST;
    end else begin
      phase_q <= phase_d;
      wbank_q <= wbank_d;
      busy_q  <= busy_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sbfr_pkg::CFG_START_BYTE: start_q   <= cfg_data_i;
          sbfr_pkg::CFG_MAX_LENGTH: max_len_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    dst_q <= dst_d;
    sum_q <= sum_d;
    len_q <= len_d;
    cnt_q <= cnt_d;
  end

endmodule

>>> hdl/sbfr_back.sv
// Result emitter: two payload buffers, registered reads and the output register.
module sbfr_back #(
  parameter int PAYLOAD_DEPTH = sbfr_pkg::PAYLOAD_DEPTH_DEF,
  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbfr_pkg::mem_wr_t wr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  sbfr_pkg::desc_t   q_desc_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output sbfr_pkg::rel_t    rel_o,
  output sbfr_pkg::res_t    res_o,
  output logic              empty_o,
  input  logic              pop_i
);

  logic [7:0] mem_q [2][PAYLOAD_DEPTH];
  logic [7:0] rd_data_q;
  logic       rd_en, rd_bank;
  logic [AW-1:0] rd_addr;

  sbfr_pkg::back_e state_q, state_d;
  sbfr_pkg::desc_t desc_q, desc_d;
  sbfr_pkg::res_t  res_q, res_d;
  logic [5:0] idx_q, idx_d, idx_nx;

  assign empty_o = (state_q != sbfr_pkg::B_EMIT);
  assign res_o   = res_q;
  assign idx_nx  = idx_q + 6'd1;

  always_comb begin
    state_d = state_q;
    desc_d  = desc_q;
    res_d   = res_q;
    idx_d   = idx_q;
    q_pop_o = 1'b0;
    rel_o   = '{en: 1'b0, bank: desc_q.bank};
    rd_en   = 1'b0;
    rd_bank = desc_q.bank;
    rd_addr = idx_nx[AW-1:0];
    unique case (state_q)
      sbfr_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          desc_d  = q_desc_i;
          idx_d   = '0;
          if ((q_desc_i.status != sbfr_pkg::ST_GOOD) || (q_desc_i.flen == '0)) begin
            res_d = '{status: q_desc_i.status, source: q_desc_i.source,
                      dest: q_desc_i.dest, flen: q_desc_i.flen, data: 8'd0,
                      pos: 5'd0, last: 1'b1};
            state_d = sbfr_pkg::B_EMIT;
          end else begin
            rd_en   = 1'b1;
            rd_bank = q_desc_i.bank;
            rd_addr = '0;
            state_d = sbfr_pkg::B_LOAD;
          end
        end
      end
      sbfr_pkg::B_LOAD: begin
        res_d = '{status: sbfr_pkg::ST_GOOD, source: desc_q.source, dest: desc_q.dest,
                  flen: desc_q.flen, data: rd_data_q, pos: idx_q[4:0],
                  last: (idx_nx == desc_q.flen[5:0])};
        state_d = sbfr_pkg::B_EMIT;
      end
      sbfr_pkg::B_EMIT: begin
        if (pop_i) begin
          if (res_q.last) begin
            rel_o.en = (desc_q.status == sbfr_pkg::ST_GOOD) && (desc_q.flen != '0);
            state_d  = sbfr_pkg::B_IDLE;
          end else begin
            idx_d   = idx_nx;
            rd_en   = 1'b1;
            state_d = sbfr_pkg::B_LOAD;
          end
        end
      end
      default: begin
        state_d = sbfr_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbfr_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    res_q  <= res_d;
    idx_q  <= idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.bank][wr_addr_i] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_bank][rd_addr];
    end
  end

endmodule

>>> hdl/start_byte_frame_receiver_unit.sv
// Top level of the start byte frame receiver.
//
//   channel   direction  handshake       payload
//   byte in   input      push / full     byte_in_i
//   result    output     empty / pop     status_o .. last_flag_o
//   config    input      cfg_we_i        cfg_idx_i, cfg_data_i
//
// An input byte is taken when push is high and full is low.
// Each payload result passes from the buffer through the read data register into the output register.
// Two payload buffers let a new frame arrive while the previous one is emitted.
// Full rises during payload bytes while both buffers are waiting to be emitted,
// and on the length and checksum bytes while the descriptor queue is full.
// Reset restores the configuration registers and clears all control state.
module start_byte_frame_receiver_unit #(
  parameter int PAYLOAD_DEPTH = sbfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_in_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status_o,
  output logic [7:0] source_id_o,
  output logic [7:0] dest_id_o,
  output logic [7:0] frame_length_o,
  output logic [7:0] data_byte_o,
  output logic [4:0] position_o,
  output logic       last_flag_o
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  sbfr_pkg::desc_t   push_desc, head_desc;
  sbfr_pkg::mem_wr_t wr;
  sbfr_pkg::rel_t    rel;
  sbfr_pkg::res_t    res;
  logic [AW-1:0]     wr_addr;
  logic              q_push, q_full, q_pop, q_empty;

  sbfr_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .byte_i     (byte_in_i),
    .full_o     (full),
    .q_push_o   (q_push),
    .q_desc_o   (push_desc),
    .q_full_i   (q_full),
    .wr_o       (wr),
    .wr_addr_o  (wr_addr),
    .rel_i      (rel)
  );

  sbfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .desc_o  (head_desc),
    .empty_o (q_empty)
  );

  sbfr_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .q_desc_i  (head_desc),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .rel_o     (rel),
    .res_o     (res),
    .empty_o   (empty),
    .pop_i     (pop)
  );

  assign status_o       = res.status;
  assign source_id_o    = res.source;
  assign dest_id_o      = res.dest;
  assign frame_length_o = res.flen;
  assign data_byte_o    = res.data;
  assign position_o     = res.pos;
  assign last_flag_o    = res.last;

endmodule

>>> hdl/sbfr_checker.sv
// Port checker of the frame receiver and its bind to the top level.
`include "start_byte_frame_receiver_unit_assert.svh"

module sbfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [1:0] status_o,
  input logic [7:0] source_id_o,
  input logic [7:0] dest_id_o,
  input logic [7:0] frame_length_o,
  input logic [7:0] data_byte_o,
  input logic [4:0] position_o,
  input logic       last_flag_o
);

  logic [39:0] res_word;
  logic        is_good, has_payload, no_data, pos_is_last;

  assign res_word    = {status_o, source_id_o, dest_id_o, frame_length_o, data_byte_o,
                        position_o, last_flag_o};
  assign is_good     = (status_o == sbfr_pkg::ST_GOOD);
  assign has_payload = is_good && (frame_length_o != 8'd0);
  assign no_data     = (data_byte_o == 8'd0) && (position_o == 5'd0);
  assign pos_is_last = (({3'b000, position_o} + 8'd1) == frame_length_o);

  `SBFR_ASSERT_NEXT(a_hold_word, !empty && !pop, !empty && $stable(res_word))
  `SBFR_ASSERT(a_status_code, empty || (status_o != 2'd3))
  `SBFR_ASSERT(a_error_single, empty || is_good || (last_flag_o && no_data))
  `SBFR_ASSERT(a_last_position, empty || !has_payload || (last_flag_o == pos_is_last))

endmodule

bind start_byte_frame_receiver_unit sbfr_checker u_sbfr_checker (.*);
